// ===== hdl/pvt_pkg.sv =====
// ----------------------------------------------------------------------------
// pvt_pkg - shared types for the projective vertex transform
// Config register codes, the payload that travels down the divider chain.
// ----------------------------------------------------------------------------
package pvt_pkg;

  localparam int NUM_CELLS = 32;   // one quotient bit per cell
  localparam int NUM_REGS  = 8;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][63:0] matrix_t;

  // identity in Q16.16, register 7 first
  localparam matrix_t MAT_IDENTITY = {
    64'h0001_0000_0000_0000,   // row 3, cols 2/3
    64'h0000_0000_0000_0000,   // row 3, cols 0/1
    64'h0000_0000_0001_0000,   // row 2, cols 2/3
    64'h0000_0000_0000_0000,   // row 2, cols 0/1
    64'h0000_0000_0000_0000,   // row 1, cols 2/3
    64'h0001_0000_0000_0000,   // row 1, cols 0/1
    64'h0000_0000_0000_0000,   // row 0, cols 2/3
    64'h0000_0000_0001_0000    // row 0, cols 0/1
  };

  // one vertex in flight through the divider chain
  typedef struct packed {
    logic [2:0][63:0] rem;    // partial remainders, x/y/z
    logic [2:0][31:0] nbits;  // numerator bits still to shift in
    logic [2:0][31:0] quo;    // quotient bits so far
    logic [63:0]      dmag;   // |w|
    logic [2:0]       neg;    // quotient sign
    logic [2:0]       ovf;    // quotient known to exceed 32 bits
    logic             wz;     // w was zero
    logic             last;
  } div_t;

endpackage

// ===== hdl/pvt_front.sv =====
// ----------------------------------------------------------------------------
// pvt_front - matrix product, row sums and divider set-up
// Four registered stages: products, sums, magnitudes, overflow test.
// ----------------------------------------------------------------------------
module pvt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [3:0]      en,
  input  logic            in_valid,
  input  logic [31:0]     src_x,
  input  logic [31:0]     src_y,
  input  logic [31:0]     src_z,
  input  logic            last_in,
  input  pvt_pkg::matrix_t mat,
  output logic [3:0]      vld,
  output pvt_pkg::div_t   dout
);
  import pvt_pkg::*;

  logic [3:0] vld_r;

  // stage 1
  logic signed [3:0][2:0][63:0] prod_r;
  logic signed [3:0][63:0]      cst_r;
  logic                         last1_r;
  // stage 2
  logic signed [3:0][65:0]      sum_r;
  logic                         last2_r;
  // stage 3
  logic [2:0][63:0]             nmag_r;
  logic [63:0]                  dmag_r;
  logic [2:0]                   neg_r;
  logic                         wz_r;
  logic                         last3_r;
  // stage 4
  div_t                         d_r;

  logic signed [31:0] src [3];
  logic signed [3:0][65:0] sum_nxt;
  logic [65:0] wabs;
  logic [2:0][65:0] nabs;

  assign src[0] = src_x;
  assign src[1] = src_y;
  assign src[2] = src_z;

  // element selects are unsigned, so sign-extend explicitly
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = 66'($signed(prod_r[r][0])) + 66'($signed(prod_r[r][1]))
                   + 66'($signed(prod_r[r][2])) + 66'($signed(cst_r[r]));
    end
    wabs = sum_r[3][65] ? -sum_r[3] : sum_r[3];
    for (int r = 0; r < 3; r++) begin
      nabs[r] = sum_r[r][65] ? -sum_r[r] : sum_r[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= $signed(mat[2*r][31:0])    * src[0];
        prod_r[r][1] <= $signed(mat[2*r][63:32])   * src[1];
        prod_r[r][2] <= $signed(mat[2*r+1][31:0])  * src[2];
        cst_r[r]     <= {{16{mat[2*r+1][63]}}, mat[2*r+1][63:32], 16'h0000};
      end
      last1_r <= last_in;
    end
    if (en[1]) begin
      sum_r   <= sum_nxt;
      last2_r <= last1_r;
    end
    if (en[2]) begin
      dmag_r <= wabs[63:0];
      wz_r   <= (sum_r[3] == '0);
      for (int r = 0; r < 3; r++) begin
        nmag_r[r] <= nabs[r][63:0];
        neg_r[r]  <= sum_r[r][65] ^ sum_r[3][65];
      end
      last3_r <= last2_r;
    end
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        d_r.rem[r]   <= {16'h0000, nmag_r[r][63:16]};
        d_r.nbits[r] <= {nmag_r[r][15:0], 16'h0000};
        d_r.quo[r]   <= '0;
        d_r.ovf[r]   <= ({16'h0000, nmag_r[r][63:16]} >= dmag_r);
      end
      d_r.dmag <= dmag_r;
      d_r.neg  <= neg_r;
      d_r.wz   <= wz_r;
      d_r.last <= last3_r;
    end
  end

  assign vld  = vld_r;
  assign dout = d_r;

endmodule

// ===== hdl/pvt_div_cell.sv =====
// ----------------------------------------------------------------------------
// pvt_div_cell - one restoring division step for three lanes
// Shifts one numerator bit in, subtracts |w| where it fits, passes on.
// ----------------------------------------------------------------------------
module pvt_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pvt_pkg::div_t  din,
  output logic           out_valid,
  output pvt_pkg::div_t  dout
);
  import pvt_pkg::*;

  logic  valid_r;
  div_t  d_r;
  div_t  d_nxt;
  logic [64:0] trial;

  always_comb begin
    d_nxt = din;
    trial = '0;
    for (int l = 0; l < 3; l++) begin
      trial = {din.rem[l], din.nbits[l][31]};
      d_nxt.nbits[l] = {din.nbits[l][30:0], 1'b0};
      if (trial >= {1'b0, din.dmag}) begin
        d_nxt.rem[l] = 64'(trial - {1'b0, din.dmag});
        d_nxt.quo[l] = {din.quo[l][30:0], 1'b1};
      end else begin
        d_nxt.rem[l] = trial[63:0];
        d_nxt.quo[l] = {din.quo[l][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign out_valid = valid_r;
  assign dout      = d_r;

endmodule

// ===== hdl/projective_vertex_transform_unit.sv =====
// ----------------------------------------------------------------------------
// projective_vertex_transform_unit - 4x4 vertex transform with w divide
// Q16.16 vertex times a programmable projective matrix, then x/w, y/w, z/w
// through a chain of 32 division cells, saturated to Q16.16.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction payload
//  in_*     | slave     | tdata {z,y,x} 96b, tlast = last_in
//  out_*    | master    | tdata {z,y,x} 96b, tuser {clipped,w_zero}, tlast
//  cfg_*    | write     | 3-bit register index, 64-bit data, no read-back
//
//  One vertex per cycle sustained while the output is not stalled; stages: 1 multiply,
//  1 sum, 1 magnitude, 1 overflow test, 32 divider cells, 1 output register.
//  The 32-cell division chain sets the latency; every stage has its own valid
//  so bubbles are squeezed out when the output stalls.
//  Reset (synchronous, rst_n low) empties the pipe and loads the identity.
//  Configuration must only be written while the pipe is empty.
// ----------------------------------------------------------------------------
module projective_vertex_transform_unit (
  input  logic         clk,
  input  logic         rst_n,
  // src_x [31:0], src_y [63:32], src_z [95:64]
  input  logic [95:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // dst_x [31:0], dst_y [63:32], dst_z [95:64]
  output logic [95:0]  out_tdata,
  // w_zero [0], clipped [1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  import pvt_pkg::*;

  matrix_t mat_r;

  logic [3:0] fr_vld;
  logic [3:0] fr_en;
  div_t       fr_dout;

  logic [NUM_CELLS:0] cv;          // cv[0] = front output valid
  logic [NUM_CELLS:0] cen;         // cen[i] loads cell i (cen[NUM_CELLS]: output)
  div_t               cd [NUM_CELLS+1];

  logic        ov_r;
  logic [95:0] odata_r;
  logic [1:0]  ouser_r;
  logic        olast_r;

  logic [95:0] odata_nxt;
  logic [1:0]  ouser_nxt;

  // configuration registers, identity at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= MAT_IDENTITY;
    end else if (cfg_we) begin
      mat_r[cfg_index] <= cfg_wdata;
    end
  end

  // ready chain: a stage moves when it is empty or its successor moves
  always_comb begin
    cen[NUM_CELLS] = !ov_r || out_tready;
    for (int i = NUM_CELLS - 1; i >= 0; i--) begin
      cen[i] = !cv[i+1] || cen[i+1];
    end
    fr_en[3] = !fr_vld[3] || cen[0];
    for (int k = 2; k >= 0; k--) begin
      fr_en[k] = !fr_vld[k] || fr_en[k+1];
    end
  end
  assign in_tready = fr_en[0];

  pvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (fr_en),
    .in_valid (in_tvalid),
    .src_x    (in_tdata[31:0]),
    .src_y    (in_tdata[63:32]),
    .src_z    (in_tdata[95:64]),
    .last_in  (in_tlast),
    .mat      (mat_r),
    .vld      (fr_vld),
    .dout     (fr_dout)
  );

  assign cv[0] = fr_vld[3];
  assign cd[0] = fr_dout;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    pvt_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (cen[g]),
      .in_valid  (cv[g]),
      .din       (cd[g]),
      .out_valid (cv[g+1]),
      .dout      (cd[g+1])
    );
  end

  // saturate, apply sign, zero-w override
  always_comb begin
    logic [31:0] lim;
    logic [31:0] mag;
    logic        clip;
    lim  = '0;
    mag  = '0;
    clip = 1'b0;
    odata_nxt = '0;
    for (int l = 0; l < 3; l++) begin
      lim = cd[NUM_CELLS].neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag = cd[NUM_CELLS].quo[l];
      if (cd[NUM_CELLS].ovf[l] || mag > lim) begin
        mag  = lim;
        clip = 1'b1;
      end
      odata_nxt[32*l +: 32] = cd[NUM_CELLS].neg[l] ? -mag : mag;
    end
    if (cd[NUM_CELLS].wz) begin
      odata_nxt = '0;
      ouser_nxt = 2'b01;
    end else begin
      ouser_nxt = {clip, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cen[NUM_CELLS]) begin
      ov_r <= cv[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (cen[NUM_CELLS]) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
      olast_r <= cd[NUM_CELLS].last;
    end
  end

  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;
  assign out_tvalid = ov_r;

  // zero w gives zero coordinates and no clip
  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("w_zero result with non-zero data or clip");

  // an empty output register never holds up the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // pipe is empty right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

// ===== test/projective_vertex_transform_unit_test.sv =====
// ----------------------------------------------------------------------------
// projective_vertex_transform_unit_test - self-checking bench for the unit
// Drives Q16.16 vertices through several matrix settings, predicts each
// projected vertex (exact row sums, truncating divide, saturation, zero w)
// and compares every output transaction in order. Both sides idle at random;
// one long output hold fills the pipe, one pause lets it drain completely.
// ----------------------------------------------------------------------------
module projective_vertex_transform_unit_test;
  import pvt_pkg::*;

  localparam int DRAIN_CYCLES = 40;    // settle time after the last result
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;  // cycles without any transaction

  typedef struct {
    logic [31:0] x, y, z;
    logic        wz, clip, last;
  } proj_vertex_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [95:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // bench copy of the matrix registers
  logic [63:0]  matrix_copy [NUM_REGS];
  proj_vertex_t pending_vertices [$];
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           quiet_mode = 1'b0;   // no idling in the last part
  bit           hold_request = 1'b0;

  projective_vertex_transform_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: exact Q32.32 row sums, |num|<<16 / |w|, sign applied after
  // --------------------------------------------------------------------------
  function automatic logic signed [127:0] row_sum(int r, logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
    logic signed [127:0] c0, c1, c2, c3, xe, ye, ze;
    c0 = $signed(matrix_copy[2*r][31:0]);
    c1 = $signed(matrix_copy[2*r][63:32]);
    c2 = $signed(matrix_copy[2*r+1][31:0]);
    c3 = $signed(matrix_copy[2*r+1][63:32]);
    xe = x;
    ye = y;
    ze = z;
    return c0 * xe + c1 * ye + c2 * ze + (c3 <<< 16);
  endfunction

  function automatic proj_vertex_t project(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic last);
    proj_vertex_t res;
    logic signed [127:0] w, n;
    logic [127:0] dmag, nmag, q, limit;
    logic [31:0] dst [3];
    bit neg;
    res = '{x: '0, y: '0, z: '0, wz: 1'b0, clip: 1'b0, last: last};
    w = row_sum(3, x, y, z);
    if (w == 0) begin
      res.wz = 1'b1;
      return res;
    end
    dmag = (w < 0) ? -w : w;
    for (int r = 0; r < 3; r++) begin
      n = row_sum(r, x, y, z);
      nmag = (n < 0) ? -n : n;
      neg = (n < 0) != (w < 0);
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      q = (nmag << 16) / dmag;
      if (q > limit) begin
        q = limit;
        res.clip = 1'b1;
      end
      dst[r] = neg ? -q[31:0] : q[31:0];
    end
    res.x = dst[0];
    res.y = dst[1];
    res.z = dst[2];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // checks each output transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected output transaction %h", out_tdata);
        error_count++;
      end else begin
        proj_vertex_t exp_v;
        exp_v = pending_vertices.pop_front();
        if (out_tdata[31:0] !== exp_v.x) begin
          $error("dst_x: expected %h, got %h", exp_v.x, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== exp_v.y) begin
          $error("dst_y: expected %h, got %h", exp_v.y, out_tdata[63:32]);
          error_count++;
        end
        if (out_tdata[95:64] !== exp_v.z) begin
          $error("dst_z: expected %h, got %h", exp_v.z, out_tdata[95:64]);
          error_count++;
        end
        if (out_tuser[0] !== exp_v.wz) begin
          $error("w_zero: expected %b, got %b", exp_v.wz, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== exp_v.clip) begin
          $error("clipped: expected %b, got %b", exp_v.clip, out_tuser[1]);
          error_count++;
        end
        if (out_tlast !== exp_v.last) begin
          $error("last_out: expected %b, got %b", exp_v.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // one input transaction; tvalid stays high on return
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic last);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tdata  <= {z, y, x};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_vertices.push_back(project(x, y, z, last));
  endtask

  // stop sending, wait for every result, then let the pipe settle
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_we drops again before the task returns so writes never share a step
  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    matrix_copy[idx] = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // coefficient of random magnitude so quotients land in range often
  function automatic logic [31:0] rand_word();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  task automatic load_random_matrix();
    reg_idx_t idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_t'(i);
      write_reg(idx, {rand_word(), rand_word()});
    end
    // w row now and then cleared to force zero w
    if ($urandom_range(0, 5) == 0) begin
      write_reg(REG_ROW3_C01, '0);
      write_reg(REG_ROW3_C23, '0);
    end
  endtask

  task automatic send_random_batch(int count);
    for (int i = 0; i < count; i++)
      send_vertex($urandom_range(0, 1) ? $urandom : rand_word(),
                  $urandom_range(0, 1) ? $urandom : rand_word(),
                  $urandom_range(0, 1) ? $urandom : rand_word(),
                  $urandom_range(0, 7) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // identity after reset: coordinate extremes pass straight through
  task automatic test_identity_extremes();
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b1);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA, 1'b0);
    drain_pipe();
  endtask

  // zero w, saturation both ways, extreme coefficients
  task automatic test_special_cases();
    // w row zero: outputs zero, w_zero set
    write_reg(REG_ROW3_C23, '0);
    send_vertex(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    drain_pipe();
    // w = z: sign flips and small w give saturation in both directions
    write_reg(REG_ROW3_C23, 64'h0000_0000_0001_0000);
    write_reg(REG_ROW0_C01, 64'h0000_0000_7FFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h1, 32'h0000_0001, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    drain_pipe();
    // most negative coefficients everywhere, then all-ones in odd and most positive in even registers
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_idx_t'(i), 64'h8000_0000_8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain_pipe();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_idx_t'(i), (i % 2) ? 64'hFFFF_FFFF_FFFF_FFFF
                                       : 64'h7FFF_FFFF_7FFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1);
    drain_pipe();
  endtask

  // random matrices, random vertices, random idling on both sides
  task automatic test_random_matrices();
    for (int p = 0; p < 9; p++) begin
      load_random_matrix();
      send_random_batch(100);
      drain_pipe();
    end
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    load_random_matrix();
    hold_request = 1'b1;
    send_random_batch(100);
    drain_pipe();
  endtask

  // sender pauses until everything is back, then a gapless stream
  task automatic test_full_rate();
    load_random_matrix();
    send_random_batch(40);
    in_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    quiet_mode = 1'b1;
    send_random_batch(150);
    drain_pipe();
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) matrix_copy[i] = '0;
    matrix_copy[REG_ROW0_C01] = 64'h0000_0000_0001_0000;
    matrix_copy[REG_ROW1_C01] = 64'h0001_0000_0000_0000;
    matrix_copy[REG_ROW2_C23] = 64'h0000_0000_0001_0000;
    matrix_copy[REG_ROW3_C23] = 64'h0001_0000_0000_0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_extremes();
    test_special_cases();
    test_random_matrices();
    test_backpressure();
    test_full_rate();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pvt_pkg.sv
hdl/pvt_front.sv
hdl/pvt_div_cell.sv
hdl/projective_vertex_transform_unit.sv
test/projective_vertex_transform_unit_test.sv
